// ===== rtl/mlt_pkg.sv =====
package mlt_pkg;

	// Number of locks held in the table.
	localparam int LOCK_COUNT = 16;
	localparam int LOCK_IDX_W = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;

	// Command codes.
	localparam logic [2:0] CMD_READ        = 3'd0;
	localparam logic [2:0] CMD_CPU_ACQ     = 3'd1;
	localparam logic [2:0] CMD_CPU_REL     = 3'd2;
	localparam logic [2:0] CMD_CHAN_ACQ    = 3'd3;
	localparam logic [2:0] CMD_CHAN_REL    = 3'd4;
	localparam logic [2:0] CMD_CLEAR_ALL   = 3'd5;

	// Status codes.
	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_REFUSED = 2'd1;
	localparam logic [1:0] STAT_WAIT    = 2'd2;

	typedef logic [2:0]  cmd_t;
	typedef logic [1:0]  status_t;
	typedef logic [3:0]  chan_t;
	typedef logic [10:0] word_t;

	// One lock entry: owner channel, cpu owns, a channel owns.
	typedef struct packed {
		chan_t owner;
		logic  cpu_own;
		logic  chan_own;
	} entry_t;

	// One request as carried through the input stage.
	typedef struct packed {
		cmd_t  cmd;
		logic [3:0] lock_id;
		chan_t channel_id;
		logic  channel_enabled;
	} req_t;

	// Outcome of one entry update.
	typedef struct packed {
		entry_t  entry;
		status_t status;
	} upd_t;

	// Lock word as seen by the requester.
	function automatic word_t word_of(input entry_t e);
		return {e.owner, 5'b0, e.cpu_own, e.chan_own};
	endfunction

endpackage

// ===== rtl/mlt_cmd_if.sv =====
interface mlt_cmd_if;
	logic                valid;
	logic                ready;
	mlt_pkg::cmd_t       cmd;
	logic [3:0]          lock_id;
	mlt_pkg::chan_t      channel_id;
	logic                channel_enabled;

	modport source (output valid, output cmd, output lock_id, output channel_id,
		output channel_enabled, input ready);
	modport sink (input valid, input cmd, input lock_id, input channel_id,
		input channel_enabled, output ready);
endinterface

// ===== rtl/mlt_res_if.sv =====
interface mlt_res_if;
	logic                valid;
	logic                ready;
	mlt_pkg::word_t      lock_word;
	mlt_pkg::status_t    status;

	modport source (output valid, output lock_word, output status, input ready);
	modport sink (input valid, input lock_word, input status, output ready);
endinterface

// ===== rtl/mlt_lock_update.sv =====
module mlt_lock_update (
	input  mlt_pkg::req_t   req,
	input  mlt_pkg::entry_t cur,
	output mlt_pkg::upd_t   upd
);
	import mlt_pkg::*;

	logic chan_busy;
	logic foreign_owner;

	// An enabled channel must wait while anyone holds the lock.
	assign chan_busy = cur.chan_own | cur.cpu_own;
	// For a release, the lock is held by the cpu or by some other channel.
	assign foreign_owner = cur.cpu_own | (cur.chan_own & (cur.owner != req.channel_id));

	// Next state of the addressed entry and the status reported.
	always_comb begin
		upd.entry  = cur;
		upd.status = STAT_DONE;
		unique case (req.cmd)
			CMD_CPU_ACQ: begin
				if (!cur.chan_own) begin
					upd.entry.cpu_own = 1'b1;
				end else if (!cur.cpu_own) begin
					upd.status = STAT_REFUSED;
				end
			end
			CMD_CPU_REL: begin
				upd.entry.cpu_own  = 1'b0;
				upd.entry.chan_own = 1'b0;
			end
			CMD_CHAN_ACQ: begin
				if (req.channel_enabled && chan_busy) begin
					upd.status = STAT_WAIT;
				end else begin
					upd.entry.chan_own = 1'b1;
					upd.entry.owner    = req.channel_id;
				end
			end
			CMD_CHAN_REL: begin
				if (req.channel_enabled && foreign_owner) begin
					upd.status = STAT_WAIT;
				end else begin
					upd.entry.chan_own = 1'b0;
				end
			end
			default: begin
				// Reads and unused codes leave the entry as it is.
				upd.entry = cur;
			end
		endcase
	end

endmodule

// ===== rtl/module_lock_table_core.sv =====
// Lock table with one command per transfer: every request gives exactly one
// result (it is held in the input register, then the table is read, updated
// and written back while the result register is loaded). The rate is one
// request per cycle unless the result side stalls, limited only by the
// single read-modify-write of the table per cycle; back-to-back requests to
// the same lock see each other's updates. A channel told to wait finds the
// table unchanged and should send its request again. Clear all empties the
// whole table and reports a zero lock word. The table is empty after reset.
module module_lock_table_core (
	input  logic clk,
	input  logic arst_n,
	mlt_cmd_if.sink   req,
	mlt_res_if.source rsp
);
	import mlt_pkg::*;

	entry_t                  entries_q [LOCK_COUNT];
	req_t                    req_s1;
	logic                    valid_s1;
	logic                    out_valid_q;
	word_t                   lock_word_q;
	status_t                 status_q;

	logic                    advance;
	logic                    in_range;
	logic [LOCK_IDX_W-1:0]   idx;
	entry_t                  cur;
	upd_t                    upd;

	// The input stage moves on whenever the result register is free or drained.
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Look up the addressed entry.
	assign in_range = (32'(req_s1.lock_id) < LOCK_COUNT);
	assign idx      = LOCK_IDX_W'(req_s1.lock_id);
	assign cur      = entries_q[idx];

	mlt_lock_update u_update (
		.req (req_s1),
		.cur (cur),
		.upd (upd)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= '{cmd: req.cmd, lock_id: req.lock_id,
				channel_id: req.channel_id, channel_enabled: req.channel_enabled};
		end
	end

	// Lock table: written back as the request completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOCK_COUNT; i++) begin
				entries_q[i] <= '0;
			end
		end else if (advance) begin
			if (req_s1.cmd == CMD_CLEAR_ALL) begin
				for (int i = 0; i < LOCK_COUNT; i++) begin
					entries_q[i] <= '0;
				end
			end else if (in_range) begin
				entries_q[idx] <= upd.entry;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if ((req_s1.cmd == CMD_CLEAR_ALL) || !in_range) begin
				lock_word_q <= '0;
				status_q    <= STAT_DONE;
			end else begin
				lock_word_q <= word_of(upd.entry);
				status_q    <= upd.status;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.lock_word = lock_word_q;
	assign rsp.status    = status_q;

endmodule
